FILE: hw/rtl/pfmc_pkg.sv
// Package for the page frame manager: opcodes, status codes, register indexes, sizes.
// Used by every module of the block; no dependencies.
package pfmc_pkg;
  localparam int unsigned FramesDef = 16;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_RELEASE = 3'd1,
    OP_REF = 3'd2,
    OP_RECORD = 3'd3,
    OP_TICK = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_WORK = 3'd1,
    ST_NO_FREE = 3'd2,
    ST_BAD_FRAME = 3'd3,
    ST_NO_VICTIM = 3'd4,
    ST_SWAP_EXH = 3'd5,
    ST_LIST_FULL = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    REG_WATERMARK = 2'd0,
    REG_FRAME_BASE = 2'd1,
    REG_LAST_SECTOR = 2'd2,
    REG_LAST_TRACK = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_EVICT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [4:0] low_watermark;
    logic [7:0] frame_base;
    logic [2:0] last_sector;
    logic [7:0] last_track;
  } cfg_t;
endpackage

FILE: hw/rtl/pfmc_cfg_regs.sv
// Configuration register file of the page frame manager.
// Depends on pfmc_pkg.
module pfmc_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output pfmc_pkg::cfg_t     cfg_o
);
  pfmc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_watermark <= 5'd2;
      cfg_q.frame_base <= 8'd64;
      cfg_q.last_sector <= 3'd7;
      cfg_q.last_track <= 8'd255;
    end else if (cfg_valid_i) begin
      unique case (pfmc_pkg::reg_e'(cfg_index_i))
        pfmc_pkg::REG_WATERMARK: cfg_q.low_watermark <= cfg_data_i[4:0];
        pfmc_pkg::REG_FRAME_BASE: cfg_q.frame_base <= cfg_data_i;
        pfmc_pkg::REG_LAST_SECTOR: cfg_q.last_sector <= cfg_data_i[2:0];
        pfmc_pkg::REG_LAST_TRACK: cfg_q.last_track <= cfg_data_i;
        default: ;
      endcase
    end
  end
endmodule

FILE: hw/rtl/page_frame_manager_clock_top.sv
// Top level of the page frame manager with a second-chance clock sweep.
// Depends on pfmc_pkg and pfmc_cfg_regs.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid_i/in_ready_o  opcode, frame, owner, page, segment, slot_in
//  out      source     out_valid_o/out_ready_i status, frame_out, evicted, victim_*
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick sweeps at most 3*FRAMES frames and reports no victim when none is found within that bound,
// probing a single frame per cycle.
// A new transaction is accepted the cycle after the result is taken.
// Reset restores register defaults and the free list in order, all frames absent.
// The result register holds until taken; no new transaction is accepted meanwhile.
module page_frame_manager_clock_top #(
  parameter int unsigned FRAMES = pfmc_pkg::FramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  frame_i,
  input  logic [2:0]  owner_i,
  input  logic [4:0]  page_i,
  input  logic [1:0]  segment_i,
  input  logic [10:0] slot_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  frame_out_o,
  output logic        evicted_o,
  output logic [2:0]  victim_owner_o,
  output logic [4:0]  victim_page_o,
  output logic [10:0] victim_slot_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned LW = $clog2(3 * FRAMES + 1);
  localparam logic [CW-1:0] FullC = CW'(FRAMES);
  localparam logic [LW-1:0] LimitC = LW'(3 * FRAMES);
  localparam logic [IW-1:0] LastI = IW'(FRAMES - 1);

  pfmc_pkg::cfg_t cfg;
  pfmc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  logic [IW-1:0] queue_q [FRAMES];
  logic [IW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [FRAMES-1:0] present_q, ref_q, evict_ok_q, slot_v_q;
  logic [7:0] info_q [FRAMES];
  logic [10:0] slot_q [FRAMES];
  logic [IW-1:0] hand_q, idx_q;
  logic [11:0] next_slot_q;
  logic [LW-1:0] steps_q;
  pfmc_pkg::state_e state_q, state_d;

  logic [2:0] op_q, owner_q;
  logic [4:0] page_q;
  logic [1:0] seg_q;
  logic [10:0] slin_q;
  logic [7:0] fdiff_q;

  logic [2:0] st_q;
  logic [7:0] fo_q;
  logic ev_q;
  logic [2:0] vo_q;
  logic [4:0] vp_q;
  logic [10:0] vs_q;

  logic [IW-1:0] off;
  logic in_pool;
  logic [IW-1:0] idx_nx;
  logic [IW:0] tail_sum;
  logic [IW-1:0] tail;
  logic [2:0] sec_nx;
  logic [7:0] trk_nx;
  logic exh_nx;
  logic tick_go;
  pfmc_pkg::status_e pre_st;

  assign off = fdiff_q[IW-1:0];
  assign in_pool = ({24'd0, fdiff_q} < 32'(FRAMES)) && present_q[off];
  assign idx_nx = (idx_q == LastI) ? '0 : idx_q + 1'b1;
  assign tail_sum = {1'b0, head_q} + (IW+1)'(count_q);
  assign tail = (tail_sum >= (IW+1)'(FRAMES)) ? IW'(tail_sum - (IW+1)'(FRAMES)) :
                tail_sum[IW-1:0];
  assign tick_go = {3'd0, count_q} <= (CW+3)'(cfg.low_watermark);

  always_comb begin
    sec_nx = next_slot_q[2:0];
    trk_nx = next_slot_q[10:3];
    exh_nx = 1'b0;
    if (next_slot_q[2:0] < cfg.last_sector) begin
      sec_nx = next_slot_q[2:0] + 3'd1;
    end else begin
      sec_nx = 3'd0;
      if (next_slot_q[10:3] < cfg.last_track) trk_nx = next_slot_q[10:3] + 8'd1;
      else exh_nx = 1'b1;
    end
  end

  always_comb begin
    pre_st = pfmc_pkg::ST_OK;
    unique case (op_q)
      pfmc_pkg::OP_ALLOC: if (count_q == '0) pre_st = pfmc_pkg::ST_NO_FREE;
      pfmc_pkg::OP_RELEASE: begin
        if (!in_pool) pre_st = pfmc_pkg::ST_BAD_FRAME;
        else if (count_q >= FullC) pre_st = pfmc_pkg::ST_LIST_FULL;
      end
      pfmc_pkg::OP_REF: if (!in_pool) pre_st = pfmc_pkg::ST_BAD_FRAME;
      pfmc_pkg::OP_RECORD: if (!in_pool) pre_st = pfmc_pkg::ST_BAD_FRAME;
      pfmc_pkg::OP_TICK: if (!tick_go) pre_st = pfmc_pkg::ST_NO_WORK;
      default: pre_st = pfmc_pkg::ST_NO_WORK;
    endcase
  end

  assign in_ready_o = (state_q == pfmc_pkg::S_IDLE) && !out_valid_o;
  assign out_valid_o = (state_q == pfmc_pkg::S_DONE);
  assign status_o = st_q;
  assign frame_out_o = fo_q;
  assign evicted_o = ev_q;
  assign victim_owner_o = vo_q;
  assign victim_page_o = vp_q;
  assign victim_slot_o = vs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pfmc_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfmc_pkg::S_IDLE: if (in_valid_i && in_ready_o) state_d = pfmc_pkg::S_EVICT;
      pfmc_pkg::S_EVICT: begin
        if (op_q == pfmc_pkg::OP_TICK && tick_go) state_d = pfmc_pkg::S_SWEEP;
        else state_d = pfmc_pkg::S_DONE;
      end
      pfmc_pkg::S_SWEEP: begin
        if (steps_q == LimitC) state_d = pfmc_pkg::S_DONE;
        else if (present_q[idx_q] && evict_ok_q[idx_q] && !ref_q[idx_q])
          state_d = pfmc_pkg::S_DONE;
      end
      pfmc_pkg::S_DONE: if (out_ready_i) state_d = pfmc_pkg::S_IDLE;
      default: state_d = pfmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRAMES; k++) queue_q[k] <= IW'(k);
      head_q <= '0;
      count_q <= FullC;
      present_q <= '0;
      ref_q <= '0;
      slot_v_q <= '0;
      hand_q <= '0;
      next_slot_q <= '0;
    end else begin
      if (state_q == pfmc_pkg::S_EVICT) begin
        unique case (op_q)
          pfmc_pkg::OP_ALLOC: if (count_q != '0) begin
            head_q <= (head_q == LastI) ? '0 : head_q + 1'b1;
            count_q <= count_q - 1'b1;
            present_q[queue_q[head_q]] <= 1'b1;
            ref_q[queue_q[head_q]] <= 1'b0;
            slot_v_q[queue_q[head_q]] <= 1'b0;
          end
          pfmc_pkg::OP_RELEASE: if (in_pool && count_q < FullC) begin
            queue_q[tail] <= off;
            count_q <= count_q + 1'b1;
            present_q[off] <= 1'b0;
            ref_q[off] <= 1'b0;
            slot_v_q[off] <= 1'b0;
          end
          pfmc_pkg::OP_REF: if (in_pool) ref_q[off] <= 1'b1;
          pfmc_pkg::OP_RECORD: if (in_pool) slot_v_q[off] <= 1'b1;
          default: ;
        endcase
      end
      if (state_q == pfmc_pkg::S_SWEEP && steps_q != LimitC &&
          present_q[idx_q] && evict_ok_q[idx_q]) begin
        if (ref_q[idx_q]) ref_q[idx_q] <= 1'b0;
        else if (count_q < FullC && (slot_v_q[idx_q] || !next_slot_q[11])) begin
          if (!slot_v_q[idx_q]) next_slot_q <= {exh_nx, trk_nx, sec_nx};
          queue_q[tail] <= idx_q;
          count_q <= count_q + 1'b1;
          present_q[idx_q] <= 1'b0;
          slot_v_q[idx_q] <= 1'b0;
          hand_q <= idx_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= opcode_i;
      owner_q <= owner_i;
      page_q <= page_i;
      seg_q <= segment_i;
      slin_q <= slot_in_i;
      fdiff_q <= frame_i - cfg.frame_base;
    end
    if (state_q == pfmc_pkg::S_EVICT) begin
      idx_q <= hand_q;
      steps_q <= '0;
      fo_q <= (op_q == pfmc_pkg::OP_ALLOC && count_q != '0) ?
              cfg.frame_base + 8'(queue_q[head_q]) : 8'd0;
      ev_q <= 1'b0;
      vo_q <= 3'd0;
      vp_q <= 5'd0;
      vs_q <= 11'd0;
      st_q <= pre_st;
      unique case (op_q)
        pfmc_pkg::OP_ALLOC: begin
          if (count_q != '0) begin
            info_q[queue_q[head_q]] <= {owner_q, page_q};
            evict_ok_q[queue_q[head_q]] <= (seg_q == 2'd1);
          end
        end
        pfmc_pkg::OP_RECORD: if (in_pool) slot_q[off] <= slin_q;
        default: ;
      endcase
    end
    if (state_q == pfmc_pkg::S_SWEEP) begin
      steps_q <= steps_q + 1'b1;
      idx_q <= idx_nx;
      if (steps_q == LimitC) st_q <= pfmc_pkg::ST_NO_VICTIM;
      else if (present_q[idx_q] && evict_ok_q[idx_q] && !ref_q[idx_q]) begin
        if (count_q >= FullC) st_q <= pfmc_pkg::ST_LIST_FULL;
        else if (!slot_v_q[idx_q] && next_slot_q[11]) st_q <= pfmc_pkg::ST_SWAP_EXH;
        else begin
          ev_q <= 1'b1;
          vo_q <= info_q[idx_q][7:5];
          vp_q <= info_q[idx_q][4:0];
          vs_q <= slot_v_q[idx_q] ? slot_q[idx_q] : next_slot_q[10:0];
          fo_q <= cfg.frame_base + 8'(idx_q);
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullC)
    else $error("free count above pool size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped before taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pfmc_pkg::S_SWEEP |-> steps_q <= LimitC)
    else $error("sweep overran limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> status_o == pfmc_pkg::ST_OK)
    else $error("eviction with error status");
endmodule
